// ----- rtl/impq_pkg.sv -----
// ----------------------------------------------------------------------------
// impq_pkg
// Shared types and constants of the indexed max priority queue: command and
// status codes, transaction structs and the controller/datapath interface.
// ----------------------------------------------------------------------------
package impq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [ID_W-1:0]         element_id;
    logic signed [VAL_W-1:0] element_value;
  } impq_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] queried_value;
    logic                    top_valid;
    logic [ID_W-1:0]         top_id;
    logic signed [VAL_W-1:0] top_value;
    logic [CNT_W-1:0]        element_count;
  } impq_out_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  // heap read address selection
  typedef enum logic [2:0] {
    RA_ROOT   = 3'd0,
    RA_LAST   = 3'd1,
    RA_PARENT = 3'd2,
    RA_LEFT   = 3'd3,
    RA_RIGHT  = 3'd4,
    RA_POS    = 3'd5
  } ra_sel_e;

  // commands from the controller
  typedef struct packed {
    logic    load_item;
    logic    set_status;
    status_e status;
    logic    ins_init;
    logic    heap_re;
    ra_sel_e ra_sel;
    logic    pos_re;
    logic    k_clear;
    logic    k_from_pos;
    logic    clr_item;
    logic    clr_root;
    logic    dec_count;
    logic    load_cur;
    logic    load_left;
    logic    move_up;
    logic    move_down;
    logic    fin_write;
    logic    q_load;
    logic    out_fire;
  } impq_ctl_t;

  // status back to the controller
  typedef struct packed {
    cmd_e command;
    logic present;
    logic full;
    logic empty;
    logic k_zero;
    logic k_last;
    logic parent_less;
    logic l_in;
    logic down_move;
  } impq_sts_t;

endpackage

// ----- rtl/impq_dpath.sv -----
// ----------------------------------------------------------------------------
// impq_dpath
// Heap memory, position map, presence bits, count, working registers and the
// result register of the indexed max priority queue.
// ----------------------------------------------------------------------------
module impq_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  impq_pkg::impq_in_t item_i,
  input  impq_pkg::impq_ctl_t ctl_i,
  output impq_pkg::impq_sts_t sts_o,
  output logic               valid_o,
  output impq_pkg::impq_out_t result_o
);

  impq_pkg::entry_t heap_mem [impq_pkg::CAPACITY];
  logic [impq_pkg::SLOT_W-1:0] pos_mem [impq_pkg::CAPACITY];

  impq_pkg::impq_in_t             item_q;
  logic [impq_pkg::CAPACITY-1:0]  present_q;
  logic [impq_pkg::CNT_W-1:0]     count_q;
  logic [impq_pkg::SLOT_W-1:0]    k_q;
  impq_pkg::entry_t               cur_q;
  impq_pkg::entry_t               lft_q;
  impq_pkg::entry_t               hrd_q;
  logic [impq_pkg::SLOT_W-1:0]    prd_q;
  logic [2:0]                     status_q;
  logic signed [impq_pkg::VAL_W-1:0] queried_q;
  logic                           valid_q;
  impq_pkg::impq_out_t            result_q;

  logic [impq_pkg::SLOT_W-1:0]  parent;
  logic [impq_pkg::CNT_W-1:0]   lidx;
  logic [impq_pkg::CNT_W:0]     ridx;
  logic [impq_pkg::CNT_W-1:0]   last;
  logic                         l_in;
  logic                         r_in;
  logic                         l_gt;
  logic                         r_gt;
  logic signed [impq_pkg::VAL_W-1:0] best_val;
  logic [impq_pkg::SLOT_W-1:0]  ra;
  logic                         we;
  impq_pkg::entry_t             wd;
  logic                         top_ok;

  assign parent   = (k_q - 8'd1) >> 1;
  assign lidx     = {k_q, 1'b1};
  assign ridx     = {1'b0, k_q, 1'b0} + 10'd2;
  assign last     = count_q - 9'd1;
  assign l_in     = lidx < count_q;
  assign r_in     = ridx < {1'b0, count_q};
  assign l_gt     = l_in && (lft_q.val > cur_q.val);
  assign best_val = l_gt ? lft_q.val : cur_q.val;
  assign r_gt     = r_in && (hrd_q.val > best_val);

  always_comb begin
    case (ctl_i.ra_sel)
      impq_pkg::RA_ROOT:   ra = '0;
      impq_pkg::RA_LAST:   ra = last[impq_pkg::SLOT_W-1:0];
      impq_pkg::RA_PARENT: ra = parent;
      impq_pkg::RA_LEFT:   ra = lidx[impq_pkg::SLOT_W-1:0];
      impq_pkg::RA_RIGHT:  ra = ridx[impq_pkg::SLOT_W-1:0];
      impq_pkg::RA_POS:    ra = prd_q;
      default:             ra = '0;
    endcase
  end

  // one write port shared by moves and the final placement
  always_comb begin
    we = ctl_i.move_up | ctl_i.move_down | ctl_i.fin_write;
    if (ctl_i.move_up) begin
      wd = hrd_q;
    end else if (ctl_i.move_down) begin
      wd = r_gt ? hrd_q : lft_q;
    end else begin
      wd = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[k_q]  <= wd;
      pos_mem[wd.id] <= k_q;
    end
    if (ctl_i.heap_re) begin
      hrd_q <= heap_mem[ra];
    end
    if (ctl_i.pos_re) begin
      prd_q <= pos_mem[item_q.element_id];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      count_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= ctl_i.out_fire;
      if (ctl_i.ins_init) begin
        present_q[item_q.element_id] <= 1'b1;
        count_q <= count_q + 9'd1;
      end
      if (ctl_i.clr_item) begin
        present_q[item_q.element_id] <= 1'b0;
      end
      if (ctl_i.clr_root) begin
        present_q[hrd_q.id] <= 1'b0;
      end
      if (ctl_i.dec_count) begin
        count_q <= last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      item_q    <= item_i;
      status_q  <= impq_pkg::ST_OK;
      queried_q <= '0;
    end
    if (ctl_i.set_status) begin
      status_q <= ctl_i.status;
    end
    if (ctl_i.ins_init) begin
      k_q       <= count_q[impq_pkg::SLOT_W-1:0];
      cur_q.id  <= item_q.element_id;
      cur_q.val <= item_q.element_value;
    end
    if (ctl_i.k_clear) begin
      k_q <= '0;
    end
    if (ctl_i.k_from_pos) begin
      k_q <= prd_q;
    end
    if (ctl_i.load_cur) begin
      cur_q <= hrd_q;
    end
    if (ctl_i.load_left) begin
      lft_q <= hrd_q;
    end
    if (ctl_i.move_up) begin
      k_q <= parent;
    end
    if (ctl_i.move_down) begin
      k_q <= r_gt ? ridx[impq_pkg::SLOT_W-1:0] : lidx[impq_pkg::SLOT_W-1:0];
    end
    if (ctl_i.q_load) begin
      queried_q <= hrd_q.val;
    end
    if (ctl_i.out_fire) begin
      result_q.status        <= status_q;
      result_q.queried_value <= queried_q;
      result_q.top_valid     <= top_ok;
      result_q.top_id        <= top_ok ? hrd_q.id : '0;
      result_q.top_value     <= top_ok ? hrd_q.val : '0;
      result_q.element_count <= count_q;
    end
  end

  assign top_ok = count_q != '0;

  always_comb begin
    sts_o.command     = impq_pkg::cmd_e'(item_q.command);
    sts_o.present     = present_q[item_q.element_id];
    sts_o.full        = count_q == 9'(impq_pkg::CAPACITY);
    sts_o.empty       = count_q == '0;
    sts_o.k_zero      = k_q == '0;
    sts_o.k_last      = {1'b0, k_q} == last;
    sts_o.parent_less = hrd_q.val < cur_q.val;
    sts_o.l_in        = l_in;
    sts_o.down_move   = l_gt | r_gt;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- rtl/impq_ctrl.sv -----
// ----------------------------------------------------------------------------
// impq_ctrl
// Sequencer of the indexed max priority queue: dispatches a command and walks
// the sift loops one heap level at a time.
// ----------------------------------------------------------------------------
module impq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  impq_pkg::impq_sts_t sts_i,
  output impq_pkg::impq_ctl_t ctl_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_Q_POS    = 5'd2;
  localparam logic [4:0] S_Q_VAL    = 5'd3;
  localparam logic [4:0] S_DEL_POS  = 5'd4;
  localparam logic [4:0] S_POP_ROOT = 5'd5;
  localparam logic [4:0] S_REM      = 5'd6;
  localparam logic [4:0] S_REM_LAST = 5'd7;
  localparam logic [4:0] S_REM_PAR  = 5'd8;
  localparam logic [4:0] S_UP_ISSUE = 5'd9;
  localparam logic [4:0] S_UP_CHECK = 5'd10;
  localparam logic [4:0] S_FIN      = 5'd11;
  localparam logic [4:0] S_DN_ISSUE = 5'd12;
  localparam logic [4:0] S_DN_LEFT  = 5'd13;
  localparam logic [4:0] S_DN_RIGHT = 5'd14;
  localparam logic [4:0] S_TOP      = 5'd15;
  localparam logic [4:0] S_OUT      = 5'd16;

  logic [4:0] state_q;
  logic [4:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.command)
          impq_pkg::CMD_INSERT: begin
            if (sts_i.present) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status     = impq_pkg::ST_DUP;
              state_d = S_TOP;
            end else if (sts_i.full) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status     = impq_pkg::ST_FULL;
              state_d = S_TOP;
            end else begin
              ctl_o.ins_init = 1'b1;
              state_d = S_UP_ISSUE;
            end
          end
          impq_pkg::CMD_POP: begin
            if (sts_i.empty) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status     = impq_pkg::ST_EMPTY;
              state_d = S_TOP;
            end else begin
              ctl_o.heap_re = 1'b1;
              ctl_o.ra_sel  = impq_pkg::RA_ROOT;
              ctl_o.k_clear = 1'b1;
              state_d = S_POP_ROOT;
            end
          end
          default: begin
            if (!sts_i.present) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status     = impq_pkg::ST_NOT_FOUND;
              state_d = S_TOP;
            end else begin
              ctl_o.pos_re = 1'b1;
              state_d = (sts_i.command == impq_pkg::CMD_QUERY) ? S_Q_POS : S_DEL_POS;
            end
          end
        endcase
      end
      S_Q_POS: begin
        ctl_o.heap_re = 1'b1;
        ctl_o.ra_sel  = impq_pkg::RA_POS;
        state_d = S_Q_VAL;
      end
      S_Q_VAL: begin
        ctl_o.q_load = 1'b1;
        state_d = S_TOP;
      end
      S_DEL_POS: begin
        ctl_o.k_from_pos = 1'b1;
        ctl_o.clr_item   = 1'b1;
        state_d = S_REM;
      end
      S_POP_ROOT: begin
        ctl_o.clr_root = 1'b1;
        state_d = S_REM;
      end
      S_REM: begin
        ctl_o.dec_count = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_TOP;
        end else begin
          ctl_o.heap_re = 1'b1;
          ctl_o.ra_sel  = impq_pkg::RA_LAST;
          state_d = S_REM_LAST;
        end
      end
      S_REM_LAST: begin
        ctl_o.load_cur = 1'b1;
        if (sts_i.k_zero) begin
          state_d = S_DN_ISSUE;
        end else begin
          ctl_o.heap_re = 1'b1;
          ctl_o.ra_sel  = impq_pkg::RA_PARENT;
          state_d = S_REM_PAR;
        end
      end
      S_REM_PAR: begin
        if (sts_i.parent_less) begin
          ctl_o.move_up = 1'b1;
          state_d = S_UP_ISSUE;
        end else begin
          state_d = S_DN_ISSUE;
        end
      end
      S_UP_ISSUE: begin
        if (sts_i.k_zero) begin
          state_d = S_FIN;
        end else begin
          ctl_o.heap_re = 1'b1;
          ctl_o.ra_sel  = impq_pkg::RA_PARENT;
          state_d = S_UP_CHECK;
        end
      end
      S_UP_CHECK: begin
        if (sts_i.parent_less) begin
          ctl_o.move_up = 1'b1;
          state_d = S_UP_ISSUE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ctl_o.fin_write = 1'b1;
        state_d = S_TOP;
      end
      S_DN_ISSUE: begin
        if (sts_i.l_in) begin
          ctl_o.heap_re = 1'b1;
          ctl_o.ra_sel  = impq_pkg::RA_LEFT;
          state_d = S_DN_LEFT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_LEFT: begin
        ctl_o.load_left = 1'b1;
        ctl_o.heap_re   = 1'b1;
        ctl_o.ra_sel    = impq_pkg::RA_RIGHT;
        state_d = S_DN_RIGHT;
      end
      S_DN_RIGHT: begin
        if (sts_i.down_move) begin
          ctl_o.move_down = 1'b1;
          state_d = S_DN_ISSUE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TOP: begin
        ctl_o.heap_re = 1'b1;
        ctl_o.ra_sel  = impq_pkg::RA_ROOT;
        state_d = S_OUT;
      end
      S_OUT: begin
        ctl_o.out_fire = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = state_q != S_IDLE;

endmodule

// ----- rtl/indexed_max_priority_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_max_priority_queue
// Addressable binary max-heap of (id, value) pairs with insert, delete by id,
// pop maximum and query commands.
// ----------------------------------------------------------------------------
// usage
//   a command transaction is taken at a rising edge with start high and busy
//   low; item_i carries command, element_id and element_value
//   each command gives one result transaction: result_o is shown for exactly
//   one cycle with valid_o high; the receiver cannot stall it
//   refused commands skip the heap walk; insert time grows with each level
//   climbed, delete and pop time with each level climbed or sunk
//   the heap memory has one read port: every level of a sift costs
//   one registered read (two when sinking) before the compare
//   a new command may be started in the cycle its result is shown
//   reset clears the presence bits and the count; heap and position memory
//   need no clearing since only written entries are ever read
// ----------------------------------------------------------------------------
module indexed_max_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  impq_pkg::impq_in_t  item_i,
  output logic                valid_o,
  output impq_pkg::impq_out_t result_o
);

  // controller to datapath commands and status
  impq_pkg::impq_ctl_t ctl;
  impq_pkg::impq_sts_t sts;

  impq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // memories, working registers and the result register
  impq_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  // an accepted command makes the block busy
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result strobe never follows directly on another result strobe
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$past(valid_o))
    else $error("result strobe longer than one cycle");

  // top is valid exactly when the heap holds elements
  a_top_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.top_valid == (result_o.element_count != '0)))
    else $error("top_valid disagrees with element count");

  // count never exceeds capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.element_count <= 9'd256)
    else $error("element count beyond capacity");

endmodule

// ----- tb/sv/indexed_max_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_tb
// Drives insert, delete, pop and query transactions into the heap, predicts
// every result with a behavioral heap kept in the testbench, and compares
// each result field by field.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_tb;

  localparam int HEAP_DEPTH = impq_pkg::CAPACITY;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  impq_pkg::impq_in_t  item_i;
  logic                valid_o;
  impq_pkg::impq_out_t result_o;

  indexed_max_priority_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // shadow heap used for prediction
  logic [7:0]         shadow_ids [HEAP_DEPTH];
  logic signed [31:0] shadow_vals [HEAP_DEPTH];
  int unsigned        shadow_pos [HEAP_DEPTH];
  bit                 shadow_held [HEAP_DEPTH];
  int unsigned        shadow_count = 0;

  impq_pkg::impq_in_t  pending_cmds[$];
  impq_pkg::impq_out_t expected_results[$];
  int                  error_count = 0;
  bit                  no_idle;
  bit                  hold_off;
  logic                busy_at_rise;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [7:0]         ti;
    logic signed [31:0] tv;
    ti = shadow_ids[a];
    tv = shadow_vals[a];
    shadow_ids[a] = shadow_ids[b];
    shadow_vals[a] = shadow_vals[b];
    shadow_ids[b] = ti;
    shadow_vals[b] = tv;
    shadow_pos[shadow_ids[a]] = a;
    shadow_pos[shadow_ids[b]] = b;
  endfunction

  function automatic void climb(int unsigned k);
    int unsigned p;
    while (k > 0 && k < shadow_count) begin
      p = (k - 1) / 2;
      if (!(shadow_vals[p] < shadow_vals[k])) break;
      swap_slots(p, k);
      k = p;
    end
  endfunction

  function automatic void sink(int unsigned k);
    int unsigned best, l, r;
    while (k < shadow_count) begin
      best = k;
      l = 2 * k + 1;
      r = 2 * k + 2;
      if (l < shadow_count && shadow_vals[l] > shadow_vals[best]) best = l;
      if (r < shadow_count && shadow_vals[r] > shadow_vals[best]) best = r;
      if (best == k) break;
      swap_slots(k, best);
      k = best;
    end
  endfunction

  function automatic void drop_slot(int unsigned k);
    int unsigned last;
    last = shadow_count - 1;
    swap_slots(k, last);
    shadow_held[shadow_ids[last]] = 1'b0;
    shadow_count = last;
    if (k < shadow_count) begin
      if (k > 0 && shadow_vals[(k - 1) / 2] < shadow_vals[k]) climb(k);
      else sink(k);
    end
  endfunction

  // apply one command to the shadow heap and return the expected result
  function automatic impq_pkg::impq_out_t heap_apply(impq_pkg::impq_in_t cmd);
    impq_pkg::impq_out_t res;
    bit                  known;
    known = shadow_held[cmd.element_id];
    res = '0;
    res.status = impq_pkg::ST_OK;
    case (impq_pkg::cmd_e'(cmd.command))
      impq_pkg::CMD_INSERT: begin
        if (known) res.status = impq_pkg::ST_DUP;
        else if (shadow_count >= HEAP_DEPTH) res.status = impq_pkg::ST_FULL;
        else begin
          shadow_ids[shadow_count] = cmd.element_id;
          shadow_vals[shadow_count] = cmd.element_value;
          shadow_pos[cmd.element_id] = shadow_count;
          shadow_held[cmd.element_id] = 1'b1;
          shadow_count++;
          climb(shadow_count - 1);
        end
      end
      impq_pkg::CMD_DELETE: begin
        if (!known) res.status = impq_pkg::ST_NOT_FOUND;
        else drop_slot(shadow_pos[cmd.element_id]);
      end
      impq_pkg::CMD_POP: begin
        if (shadow_count == 0) res.status = impq_pkg::ST_EMPTY;
        else drop_slot(0);
      end
      default: begin
        if (!known) res.status = impq_pkg::ST_NOT_FOUND;
        else res.queried_value = shadow_vals[shadow_pos[cmd.element_id]];
      end
    endcase
    if (shadow_count > 0) begin
      res.top_valid = 1'b1;
      res.top_id = shadow_ids[0];
      res.top_value = shadow_vals[0];
    end
    res.element_count = shadow_count[8:0];
    return res;
  endfunction

  function automatic impq_pkg::impq_in_t make_cmd(impq_pkg::cmd_e c, logic [7:0] id,
                                                  logic [31:0] v);
    impq_pkg::impq_in_t t;
    t.command = c;
    t.element_id = id;
    t.element_value = v;
    return t;
  endfunction

  // append one command to the pending list
  function automatic void add_cmd(impq_pkg::cmd_e c, logic [7:0] id, logic [31:0] v);
    pending_cmds.insert(pending_cmds.size(), make_cmd(c, id, v));
  endfunction

  // biased value: narrow range gives ties, sometimes full 32 bits
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 7);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'h7FFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  // sender decides whether to offer a transaction this cycle
  function automatic bit may_send();
    if (pending_cmds.size() == 0 || hold_off) return 1'b0;
    return no_idle || $urandom_range(0, 99) >= 37;
  endfunction

  // driver: drive at the falling edge, the transaction lands at the next rise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else if (start && !busy_at_rise) begin
      // previous transaction was taken at the last rising edge
      if (may_send()) begin
        item_i <= pending_cmds.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (may_send()) begin
        item_i <= pending_cmds.pop_front();
        start  <= 1'b1;
      end
    end
  end

  // acceptance sampled at the rising edge; predictions are made here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_at_rise <= 1'b1;
    end else begin
      busy_at_rise <= busy;
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), heap_apply(item_i));
      end
    end
  end

  // monitor: each result transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    impq_pkg::impq_out_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, result_o.status);
          error_count++;
        end
        if (result_o.queried_value !== want.queried_value) begin
          $error("queried_value exp %0d got %0d", want.queried_value,
                 result_o.queried_value);
          error_count++;
        end
        if (result_o.top_valid !== want.top_valid) begin
          $error("top_valid exp %0d got %0d", want.top_valid, result_o.top_valid);
          error_count++;
        end
        if (result_o.top_id !== want.top_id) begin
          $error("top_id exp %0d got %0d", want.top_id, result_o.top_id);
          error_count++;
        end
        if (result_o.top_value !== want.top_value) begin
          $error("top_value exp %0d got %0d", want.top_value, result_o.top_value);
          error_count++;
        end
        if (result_o.element_count !== want.element_count) begin
          $error("element_count exp %0d got %0d", want.element_count,
                 result_o.element_count);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int          n;
    int unsigned pick;
    logic [7:0]  id;
    no_idle = 1'b0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cases, extremes, ties, duplicates, delete paths
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_QUERY, 8'd255, 32'd0);
    add_cmd(impq_pkg::CMD_DELETE, 8'd7, 32'd0);
    add_cmd(impq_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);
    add_cmd(impq_pkg::CMD_INSERT, 8'd255, 32'h7FFF_FFFF);
    add_cmd(impq_pkg::CMD_INSERT, 8'd255, 32'd5);
    add_cmd(impq_pkg::CMD_INSERT, 8'd10, 32'd5);
    add_cmd(impq_pkg::CMD_INSERT, 8'd11, 32'd5);
    add_cmd(impq_pkg::CMD_INSERT, 8'd12, 32'hFFFF_FFFF);
    add_cmd(impq_pkg::CMD_INSERT, 8'd13, 32'd100);
    add_cmd(impq_pkg::CMD_QUERY, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_QUERY, 8'd255, 32'hFFFF_FFFF);
    add_cmd(impq_pkg::CMD_DELETE, 8'd10, 32'd0);
    add_cmd(impq_pkg::CMD_DELETE, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_QUERY, 8'd11, 32'd0);
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    add_cmd(impq_pkg::CMD_POP, 8'd0, 32'd0);
    wait_drained();

    // fill to capacity, then offer one duplicate insert
    no_idle = 1'b1;
    for (int i = 0; i < HEAP_DEPTH; i++)
      add_cmd(impq_pkg::CMD_INSERT, i[7:0], rand_value());
    add_cmd(impq_pkg::CMD_INSERT, 8'd3, 32'd1);
    wait_drained();
    // full heap with a fresh id is impossible since all ids are present;
    // drain part of it via 128 deletes by random id
    for (int i = 0; i < 128; i++)
      add_cmd(impq_pkg::CMD_DELETE, 8'($urandom()), 32'd0);
    wait_drained();
    no_idle = 1'b0;

    // random mix, with one sender pause until everything has come back
    for (n = 0; n < 1000; n++) begin
      pick = $urandom_range(0, 99);
      id = (pick < 80) ? 8'($urandom_range(0, 63)) : 8'($urandom());
      if (pick < 40) add_cmd(impq_pkg::CMD_INSERT, id, rand_value());
      else if (pick < 60) add_cmd(impq_pkg::CMD_DELETE, id, $urandom());
      else if (pick < 78) add_cmd(impq_pkg::CMD_POP, id, $urandom());
      else add_cmd(impq_pkg::CMD_QUERY, id, $urandom());
      if (n == 500) begin
        wait_drained();
        hold_off = 1'b1;
        repeat (5) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end
    wait_drained();
    repeat (60) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
